// File: sv/lfra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfra_pkg
// Shared types and constants of the lowest-free-room allocator.
// ----------------------------------------------------------------------------
package lfra_pkg;

  localparam int ROOMS    = 16;
  localparam int ROOM_W   = $clog2(ROOMS);
  localparam int REQ_W    = 32;
  localparam int TIME_W   = 48;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_RST  = 16;

  typedef struct packed {
    logic [REQ_W-1:0] start_time;
    logic [REQ_W-1:0] end_time;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [TIME_W-1:0] actual_start;
    logic              delayed;
    logic [ROOM_W-1:0] busiest_room;
    logic              report_valid;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_BUMP,
    ST_REPORT,
    ST_DONE
  } state_t;

  // rooms taking part: zero acts as one, anything above ROOMS as ROOMS
  function automatic logic [CFG_W-1:0] active_rooms(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] n;
    if (cfg == '0) begin
      n = CFG_W'(1);
    end else if (cfg > CFG_W'(ROOMS)) begin
      n = CFG_W'(ROOMS);
    end else begin
      n = cfg;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: sv/lfra_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfra_req_if
// Request channel: valid/ready handshake carrying one booking request word.
// ----------------------------------------------------------------------------
interface lfra_req_if;
  import lfra_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface
`default_nettype wire

// File: sv/lfra_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfra_res_if
// Result channel: valid/ready handshake carrying one allocation result word.
// ----------------------------------------------------------------------------
interface lfra_res_if;
  import lfra_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface
`default_nettype wire

// File: sv/lowest_free_room_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_room_allocator_unit
// Books each request into the lowest free room, or delays it into the room
// that frees first; reports the busiest room at the end of a batch.
// ----------------------------------------------------------------------------
//  port      dir  handshake      word
//  in_req    in   valid/ready    start_time, end_time, last_request
//  out_res   out  valid/ready    room, actual_start, delayed, busiest_room,
//                                report_valid
//  cfg_wr_*  in   write enable   rooms_in_use
//
//  A request scans the rooms in use up to the first free one, then writes
//  its finish time and count; the last request of a batch also reads the
//  counts of all rooms in use: finish times and counts sit in 16-entry
//  memories with one read port each, read one room per cycle.
//  Reset clears the per-room valid bits at once, so no clearing pass is run.
//  The result waits in an output register; a new word is taken while it
//  waits, and the block stalls only when the next result finds it still full.
// ----------------------------------------------------------------------------
module lowest_free_room_allocator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lfra_req_if.sink                        in_req,
  lfra_res_if.source                      out_res,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lfra_pkg::CFG_W-1:0] cfg_wr_data
);
  import lfra_pkg::*;

  // config and control
  logic [CFG_W-1:0]  cfg_rooms_r;
  state_t            state_r, state_nxt;
  logic [ROOM_W-1:0] iss_idx_r, iss_idx_nxt;
  logic [ROOM_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic              out_vld_r, out_vld_nxt;

  // request context
  logic [REQ_W-1:0]  start_r, start_nxt;
  logic [REQ_W-1:0]  end_r, end_nxt;
  logic [REQ_W-1:0]  dur_r, dur_nxt;
  logic              last_r, last_nxt;
  logic [ROOM_W-1:0] last_idx_r, last_idx_nxt;
  logic [ROOM_W-1:0] early_idx_r, early_idx_nxt;
  logic [TIME_W-1:0] early_val_r, early_val_nxt;
  logic [ROOM_W-1:0] best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  best_val_r, best_val_nxt;
  logic [ROOM_W-1:0] pick_r, pick_nxt;
  logic              found_r, found_nxt;
  logic [TIME_W-1:0] actual_r, actual_nxt;
  logic [ROOM_W-1:0] busy_r, busy_nxt;
  res_t              out_data_r, out_data_nxt;

  // memories
  logic [TIME_W-1:0] fin_mem [ROOMS];
  logic [CNT_W-1:0]  cnt_mem [ROOMS];
  logic [ROOMS-1:0]  fin_vld_r;
  logic [ROOMS-1:0]  cnt_vld_r;
  logic [TIME_W-1:0] fin_rd_r;
  logic              fin_rv_r;
  logic [CNT_W-1:0]  cnt_rd_r;
  logic              cnt_rv_r;
  logic [ROOM_W-1:0] fin_ra, cnt_ra;
  logic              fin_we, cnt_we, vld_clr;
  logic [TIME_W-1:0] fin_wd;
  logic [CNT_W-1:0]  cnt_wd;

  // datapath helpers
  logic [TIME_W-1:0] fin_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic              free_now, e_upd, b_upd;
  logic [ROOM_W-1:0] e_idx_c, b_idx_c;
  logic [TIME_W-1:0] e_val_c;
  logic [CNT_W-1:0]  b_val_c;
  logic [TIME_W:0]   delay_sum;
  logic [CFG_W-1:0]  act_n;

  assign in_req.ready  = (state_r == ST_IDLE);
  assign out_res.valid = out_vld_r;
  assign out_res.data  = out_data_r;

  // never-written entries read as zero
  assign fin_eff   = fin_rv_r ? fin_rd_r : '0;
  assign cnt_eff   = cnt_rv_r ? cnt_rd_r : '0;
  assign free_now  = (fin_eff <= {{(TIME_W-REQ_W){1'b0}}, start_r});
  assign e_upd     = (fin_eff < early_val_r);
  assign e_idx_c   = e_upd ? chk_idx_r : early_idx_r;
  assign e_val_c   = e_upd ? fin_eff : early_val_r;
  assign b_upd     = (cnt_eff > best_val_r);
  assign b_idx_c   = b_upd ? chk_idx_r : best_idx_r;
  assign b_val_c   = b_upd ? cnt_eff : best_val_r;
  assign delay_sum = {1'b0, actual_r} + {{(TIME_W-REQ_W+1){1'b0}}, dur_r};
  assign act_n     = active_rooms(cfg_rooms_r);

  always_comb begin
    state_nxt     = state_r;
    iss_idx_nxt   = iss_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_v_nxt     = chk_v_r;
    out_vld_nxt   = out_vld_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    dur_nxt       = dur_r;
    last_nxt      = last_r;
    last_idx_nxt  = last_idx_r;
    early_idx_nxt = early_idx_r;
    early_val_nxt = early_val_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    actual_nxt    = actual_r;
    busy_nxt      = busy_r;
    out_data_nxt  = out_data_r;
    fin_ra        = iss_idx_r;
    cnt_ra        = (state_r == ST_REPORT) ? iss_idx_r : pick_r;
    fin_we        = 1'b0;
    cnt_we        = 1'b0;
    vld_clr       = 1'b0;
    fin_wd        = '0;
    cnt_wd        = '0;

    if (out_vld_r && out_res.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          start_nxt     = in_req.data.start_time;
          end_nxt       = in_req.data.end_time;
          last_nxt      = in_req.data.last_request;
          dur_nxt       = (in_req.data.end_time > in_req.data.start_time) ?
                          (in_req.data.end_time - in_req.data.start_time) : '0;
          last_idx_nxt  = ROOM_W'(act_n - CFG_W'(1));
          iss_idx_nxt   = '0;
          chk_v_nxt     = 1'b0;
          early_idx_nxt = '0;
          early_val_nxt = '1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one room per cycle, check the one read the cycle before
        iss_idx_nxt = iss_idx_r + ROOM_W'(1);
        chk_idx_nxt = iss_idx_r;
        chk_v_nxt   = 1'b1;
        if (chk_v_r) begin
          early_idx_nxt = e_idx_c;
          early_val_nxt = e_val_c;
          if (free_now) begin
            pick_nxt   = chk_idx_r;
            found_nxt  = 1'b1;
            actual_nxt = {{(TIME_W-REQ_W){1'b0}}, start_r};
            state_nxt  = ST_WRITE;
          end else if (chk_idx_r == last_idx_r) begin
            pick_nxt   = e_idx_c;
            found_nxt  = 1'b0;
            actual_nxt = e_val_c;
            state_nxt  = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        fin_we = 1'b1;
        if (found_r) begin
          fin_wd = {{(TIME_W-REQ_W){1'b0}}, end_r};
        end else begin
          fin_wd = delay_sum[TIME_W] ? '1 : delay_sum[TIME_W-1:0];
        end
        state_nxt = ST_BUMP;
      end
      ST_BUMP: begin
        cnt_we = 1'b1;
        cnt_wd = (cnt_eff == '1) ? cnt_eff : cnt_eff + CNT_W'(1);
        if (last_r) begin
          iss_idx_nxt  = '0;
          chk_v_nxt    = 1'b0;
          best_idx_nxt = '0;
          best_val_nxt = '0;
          state_nxt    = ST_REPORT;
        end else begin
          busy_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_REPORT: begin
        iss_idx_nxt = iss_idx_r + ROOM_W'(1);
        chk_idx_nxt = iss_idx_r;
        chk_v_nxt   = 1'b1;
        if (chk_v_r) begin
          best_idx_nxt = b_idx_c;
          best_val_nxt = b_val_c;
          if (chk_idx_r == last_idx_r) begin
            busy_nxt  = b_idx_c;
            vld_clr   = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_res.ready) begin
          out_vld_nxt               = 1'b1;
          out_data_nxt.room         = pick_r;
          out_data_nxt.actual_start = actual_r;
          out_data_nxt.delayed      = !found_r;
          out_data_nxt.busiest_room = busy_r;
          out_data_nxt.report_valid = last_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_vld_r   <= 1'b0;
      chk_v_r     <= 1'b0;
      cfg_rooms_r <= CFG_W'(CFG_RST);
      fin_vld_r   <= '0;
      cnt_vld_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      chk_v_r   <= chk_v_nxt;
      if (cfg_wr_en) begin
        cfg_rooms_r <= cfg_wr_data;
      end
      if (vld_clr) begin
        fin_vld_r <= '0;
        cnt_vld_r <= '0;
      end else begin
        if (fin_we) begin
          fin_vld_r[pick_r] <= 1'b1;
        end
        if (cnt_we) begin
          cnt_vld_r[pick_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r   <= iss_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    dur_r       <= dur_nxt;
    last_r      <= last_nxt;
    last_idx_r  <= last_idx_nxt;
    early_idx_r <= early_idx_nxt;
    early_val_r <= early_val_nxt;
    best_idx_r  <= best_idx_nxt;
    best_val_r  <= best_val_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    actual_r    <= actual_nxt;
    busy_r      <= busy_nxt;
    out_data_r  <= out_data_nxt;
  end

  // finish time memory, one read and one write port
  always_ff @(posedge clk) begin
    fin_rd_r <= fin_mem[fin_ra];
    fin_rv_r <= fin_vld_r[fin_ra];
    if (fin_we) begin
      fin_mem[pick_r] <= fin_wd;
    end
  end

  // booking count memory, one read and one write port
  always_ff @(posedge clk) begin
    cnt_rd_r <= cnt_mem[cnt_ra];
    cnt_rv_r <= cnt_vld_r[cnt_ra];
    if (cnt_we) begin
      cnt_mem[pick_r] <= cnt_wd;
    end
  end

endmodule
`default_nettype wire

// File: sv/lfra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfra_checker
// Port-level checks of the room allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfra_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire lfra_pkg::res_t             out_data,
  input wire logic                       cfg_wr_en,
  input wire logic [lfra_pkg::CFG_W-1:0] cfg_wr_data
);
  import lfra_pkg::*;

  logic [CFG_W-1:0] cfg_r;
  logic [CFG_W-1:0] act_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(CFG_RST);
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  assign act_n = active_rooms(cfg_r);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one request at a time: a scan follows every accepted word
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a scan is running");

  a_busy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.report_valid |-> out_data.busiest_room == '0)
    else $error("busiest room set without a report");

  a_room_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.room} < act_n) &&
                  ({1'b0, out_data.busiest_room} < act_n))
    else $error("room outside the rooms in use");

endmodule

bind lowest_free_room_allocator_unit lfra_checker u_lfra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_data    (out_res.data),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
`default_nettype wire

// File: bench/tb_lowest_free_room_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_room_allocator_unit
// Self-checking bench for the room allocator. A walked table of directed
// bookings and room-count writes comes first. Random batches follow, with
// random idle gaps on both channels. Every result word is checked against an
// in-bench booking predictor, or against a listed result on directed rows.
// ----------------------------------------------------------------------------
module tb_lowest_free_room_allocator_unit;
  import lfra_pkg::*;

  localparam int          RANDOM_ITEMS = 1050;
  localparam int          TAIL_CYCLES  = 2 * ROOMS + 8;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] rooms;
    req_t             req;
    bit               typed;
    res_t             want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  lfra_req_if req_bus ();
  lfra_res_if res_bus ();

  lowest_free_room_allocator_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_bus),
    .out_res     (res_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [TIME_W-1:0] finish_at [ROOMS];
  logic [CNT_W-1:0]  bookings [ROOMS];
  logic [CFG_W-1:0]  rooms_cfg;

  res_t        pending_res[$];
  plan_row_t   plan[$];
  int          misses;
  int          words_seen;
  int unsigned cycle_count;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic res_t book_room(input req_t r);
    res_t             o;
    int               n;
    int               pick;
    int               early;
    int               best;
    bit               hit;
    logic [TIME_W:0]  sum;
    logic [REQ_W-1:0] dur;
    if (rooms_cfg == '0) begin
      n = 1;
    end else if (rooms_cfg > CFG_W'(ROOMS)) begin
      n = ROOMS;
    end else begin
      n = int'(rooms_cfg);
    end
    pick  = 0;
    early = 0;
    hit   = 1'b0;
    for (int i = 0; i < n && !hit; i++) begin
      if (finish_at[i] < finish_at[early]) early = i;
      if (finish_at[i] <= TIME_W'(r.start_time)) begin
        pick = i;
        hit  = 1'b1;
      end
    end
    o = '0;
    if (hit) begin
      o.actual_start  = TIME_W'(r.start_time);
      finish_at[pick] = TIME_W'(r.end_time);
    end else begin
      dur             = (r.end_time > r.start_time) ? r.end_time - r.start_time : '0;
      pick            = early;
      o.actual_start  = finish_at[pick];
      sum             = {1'b0, finish_at[pick]} + (TIME_W + 1)'(dur);
      finish_at[pick] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    end
    if (bookings[pick] != '1) bookings[pick] = bookings[pick] + 1'b1;
    o.room    = ROOM_W'(pick);
    o.delayed = !hit;
    if (r.last_request) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (bookings[i] > bookings[best]) best = i;
      end
      o.busiest_room = ROOM_W'(best);
      o.report_valid = 1'b1;
      for (int i = 0; i < ROOMS; i++) begin
        finish_at[i] = '0;
        bookings[i]  = '0;
      end
    end
    return o;
  endfunction

  function automatic plan_row_t rooms_row(input logic [CFG_W-1:0] v);
    plan_row_t p;
    p.is_cfg = 1'b1;
    p.rooms  = v;
    p.req    = '0;
    p.typed  = 1'b0;
    p.want   = '0;
    return p;
  endfunction

  function automatic plan_row_t req_row(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                                        input bit l);
    plan_row_t p;
    p                  = rooms_row('0);
    p.is_cfg           = 1'b0;
    p.req.start_time   = s;
    p.req.end_time     = e;
    p.req.last_request = l;
    return p;
  endfunction

  function automatic plan_row_t known_row(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                                          input bit l, input logic [ROOM_W-1:0] room,
                                          input logic [TIME_W-1:0] act, input bit del,
                                          input logic [ROOM_W-1:0] busy, input bit rv);
    plan_row_t p;
    p                     = req_row(s, e, l);
    p.typed               = 1'b1;
    p.want.room           = room;
    p.want.actual_start   = act;
    p.want.delayed        = del;
    p.want.busiest_room   = busy;
    p.want.report_valid   = rv;
    return p;
  endfunction

  // drive one request word, wait for it to be taken, then idle for a random gap, which may be none
  task automatic push_request(input req_t r, input bit typed, input res_t want);
    res_t predicted;
    int   gap;
    @(negedge clk);
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    do @(posedge clk); while (!req_bus.ready);
    predicted = book_room(r);
    pending_res.push_back(typed ? want : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_rooms(input logic [CFG_W-1:0] v);
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    rooms_cfg = v;
  endtask

  function automatic logic [CFG_W-1:0] pick_rooms();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(ROOMS);
      3:       return '1;
      4:       return CFG_W'(ROOMS + 1);
      default: return CFG_W'($urandom_range(1, ROOMS));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      words_seen++;
      if (pending_res.size() == 0) begin
        misses++;
        if (misses <= 10) $display("word %0d arrived with nothing expected", words_seen);
      end else begin
        want = pending_res.pop_front();
        if (res_bus.data.room !== want.room ||
            res_bus.data.actual_start !== want.actual_start ||
            res_bus.data.delayed !== want.delayed ||
            res_bus.data.busiest_room !== want.busiest_room ||
            res_bus.data.report_valid !== want.report_valid) begin
          misses++;
          if (misses <= 10) begin
            $display("word %0d want room=%0d start=%0h delayed=%0b busiest=%0d report=%0b",
                     words_seen, want.room, want.actual_start, want.delayed,
                     want.busiest_room, want.report_valid);
            $display("word %0d got  room=%0d start=%0h delayed=%0b busiest=%0d report=%0b",
                     words_seen, res_bus.data.room, res_bus.data.actual_start,
                     res_bus.data.delayed, res_bus.data.busiest_room,
                     res_bus.data.report_valid);
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        res_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0] t;
    logic [REQ_W-1:0] s;
    logic [REQ_W-1:0] e;
    logic [REQ_W-1:0] step_max;
    logic [REQ_W-1:0] dur_max;
    req_t             r;
    int               sent;
    int               blen;
    int               roll;

    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    misses        = 0;
    words_seen    = 0;
    quiet         = 1'b0;
    rooms_cfg     = CFG_W'(CFG_RST);
    for (int i = 0; i < ROOMS; i++) begin
      finish_at[i] = '0;
      bookings[i]  = '0;
    end

    // all rooms in use out of reset
    plan.push_back(known_row(0, 10, 0, 0, 0, 0, 0, 0));
    plan.push_back(req_row(5, 15, 0));
    plan.push_back(req_row(10, 20, 0));
    plan.push_back(req_row(20, 20, 0));
    plan.push_back(req_row(32'hFFFF_FFFF, 0, 1));
    // single room: free, delayed, delayed with end before start
    plan.push_back(rooms_row(1));
    plan.push_back(known_row(100, 200, 0, 0, 100, 0, 0, 0));
    plan.push_back(known_row(150, 400, 0, 0, 200, 1, 0, 0));
    plan.push_back(known_row(160, 100, 1, 0, 450, 1, 0, 1));
    // zero rooms acts as one
    plan.push_back(rooms_row(0));
    plan.push_back(known_row(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    plan.push_back(known_row(1, 5, 1, 0, 48'hFFFF_FFFF, 1, 0, 1));
    // all busy: tie on earliest finish goes to the lower room
    plan.push_back(rooms_row(3));
    plan.push_back(known_row(0, 100, 0, 0, 0, 0, 0, 0));
    plan.push_back(known_row(1, 50, 0, 1, 1, 0, 0, 0));
    plan.push_back(known_row(2, 50, 0, 2, 2, 0, 0, 0));
    plan.push_back(known_row(3, 60, 1, 1, 50, 1, 1, 1));
    // room counts above the room total
    plan.push_back(rooms_row('1));
    plan.push_back(known_row(7, 8, 1, 0, 7, 0, 0, 1));
    plan.push_back(rooms_row(CFG_W'(ROOMS + 1)));
    plan.push_back(req_row(0, 1, 0));
    plan.push_back(req_row(0, 1, 0));
    plan.push_back(req_row(32'h8000_0000, 32'h7FFF_FFFF, 1));
    plan.push_back(rooms_row(CFG_W'(ROOMS)));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_rooms(plan[i].rooms);
      end else begin
        push_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_rooms(pick_rooms());
      quiet = ($urandom_range(0, 5) == 0);
      blen  = $urandom_range(1, 24);
      t     = $urandom;
      case ($urandom_range(0, 3))
        0:       step_max = 1;
        1:       step_max = 8;
        2:       step_max = 256;
        default: step_max = 65536;
      endcase
      case ($urandom_range(0, 3))
        0:       dur_max = 4;
        1:       dur_max = 64;
        2:       dur_max = 4096;
        default: dur_max = '1;
      endcase
      for (int k = 0; k < blen; k++) begin
        if ($urandom_range(0, 32) == 0) write_rooms(pick_rooms());
        roll = $urandom_range(0, 99);
        // mostly sorted starts; a few out-of-order ones
        s = (roll < 5) ? REQ_W'($urandom) : t;
        t = t + REQ_W'($urandom_range(1, step_max));
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          e = s + REQ_W'($urandom_range(1, dur_max));
        end else if (roll < 90) begin
          e = s - REQ_W'($urandom_range(0, 3));
        end else begin
          e = $urandom;
        end
        r.start_time   = s;
        r.end_time     = e;
        r.last_request = (k == blen - 1);
        push_request(r, 1'b0, '0);
        sent++;
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (misses == 0 && pending_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: lowest_free_room_allocator_unit.f
sv/lfra_pkg.sv
sv/lfra_req_if.sv
sv/lfra_res_if.sv
sv/lowest_free_room_allocator_unit.sv
sv/lfra_checker.sv
bench/tb_lowest_free_room_allocator_unit.sv
